[rtl/cmr_pkg.sv]
package cmr_pkg;

    localparam int CP_W    = 21;
    localparam int CLS_W   = 8;
    localparam int TDATA_W = 32;
    localparam int PAD_W   = TDATA_W - CP_W - CLS_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;       // latch the incoming item
        logic ins_now;    // insert the incoming item into the mark buffer
        logic ins_held;   // insert the latched item into the mark buffer
        logic pop;        // move the buffer head to the output register
        logic emit_item;  // move the latched item to the output register
        logic out_last;
        logic out_ovf;
    } cmr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_starter;
        logic in_eot;
        logic held_eot;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic out_free;
    } cmr_stat_t;

endpackage

[rtl/cmr_datapath.sv]
module cmr_datapath #(
    parameter int MAX_RUN = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [cmr_pkg::TDATA_W-1:0] s_tdata,
    input  logic                       s_tlast,
    input  logic                       m_tready,
    input  cmr_pkg::cmr_cmd_t          cmd,
    output cmr_pkg::cmr_stat_t         stat,
    output logic                       m_tvalid,
    output logic [cmr_pkg::TDATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser
);
    import cmr_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN + 1);

    logic [CP_W-1:0]  code_reg  [MAX_RUN];
    logic [CP_W-1:0]  code_next [MAX_RUN];
    logic [CLS_W-1:0] class_reg  [MAX_RUN];
    logic [CLS_W-1:0] class_next [MAX_RUN];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [CP_W-1:0]  item_cp_reg;
    logic [CLS_W-1:0] item_cls_reg;
    logic             item_eot_reg;

    logic             out_valid_reg;
    logic [CP_W-1:0]  out_cp_reg;
    logic [CLS_W-1:0] out_cls_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic [CP_W-1:0]  in_cp;
    logic [CLS_W-1:0] in_cls;
    logic [CP_W-1:0]  ins_cp;
    logic [CLS_W-1:0] ins_cls;
    logic             ins_en;
    logic [MAX_RUN-1:0] le;

    assign in_cp   = s_tdata[CP_W-1:0];
    assign in_cls  = s_tdata[CP_W +: CLS_W];
    assign ins_cp  = cmd.ins_now ? in_cp : item_cp_reg;
    assign ins_cls = cmd.ins_now ? in_cls : item_cls_reg;
    assign ins_en  = cmd.ins_now || cmd.ins_held;

    // held entries that stay in place: the sorted prefix with class <= new class
    always_comb begin
        for (int j = 0; j < MAX_RUN; j++) begin
            le[j] = (CNT_W'(j) < cnt_reg) && (class_reg[j] <= ins_cls);
        end
    end

    always_comb begin
        code_next  = code_reg;
        class_next = class_reg;
        cnt_next   = cnt_reg;
        if (cmd.pop) begin
            for (int j = 0; j < MAX_RUN - 1; j++) begin
                code_next[j]  = code_reg[j+1];
                class_next[j] = class_reg[j+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end else if (ins_en) begin
            if (!le[0]) begin
                code_next[0]  = ins_cp;
                class_next[0] = ins_cls;
            end
            for (int j = 1; j < MAX_RUN; j++) begin
                if (!le[j]) begin
                    if (le[j-1]) begin
                        code_next[j]  = ins_cp;
                        class_next[j] = ins_cls;
                    end else begin
                        // make room: shift the larger classes up by one
                        code_next[j]  = code_reg[j-1];
                        class_next[j] = class_reg[j-1];
                    end
                end
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        class_reg <= class_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_cp_reg  <= in_cp;
            item_cls_reg <= in_cls;
            item_eot_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.pop || cmd.emit_item) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.pop) begin
            out_cp_reg   <= code_reg[0];
            out_cls_reg  <= class_reg[0];
            out_last_reg <= cmd.out_last;
            out_ovf_reg  <= cmd.out_ovf;
        end else if (cmd.emit_item) begin
            out_cp_reg   <= item_cp_reg;
            out_cls_reg  <= item_cls_reg;
            out_last_reg <= cmd.out_last;
            out_ovf_reg  <= cmd.out_ovf;
        end
    end

    assign stat.in_starter = (in_cls == '0);
    assign stat.in_eot     = s_tlast;
    assign stat.held_eot   = item_eot_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_one    = (cnt_reg == CNT_W'(1));
    assign stat.cnt_full   = (cnt_reg == CNT_W'(MAX_RUN));
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{PAD_W{1'b0}}, out_cls_reg, out_cp_reg};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

[rtl/cmr_ctrl.sv]
module cmr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cmr_pkg::cmr_stat_t stat,
    output cmr_pkg::cmr_cmd_t  cmd
);
    import cmr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_EMIT,
        ST_INSERT
    } state_t;

    typedef enum logic [1:0] {
        FK_STARTER,
        FK_OVF,
        FK_EOT
    } flush_kind_t;

    state_t      state_reg, state_next;
    flush_kind_t kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= FK_STARTER;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (stat.in_starter) begin
                        kind_next  = FK_STARTER;
                        state_next = stat.cnt_zero ? ST_EMIT : ST_FLUSH;
                    end else if (stat.cnt_full) begin
                        kind_next  = FK_OVF;
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.ins_now = 1'b1;
                        if (stat.in_eot) begin
                            kind_next  = FK_EOT;
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.pop     = 1'b1;
                    cmd.out_ovf = (kind_reg == FK_OVF);
                    // last only if nothing else follows from this item
                    cmd.out_last = stat.cnt_one &&
                        ((kind_reg == FK_EOT) || ((kind_reg == FK_OVF) && !stat.held_eot));
                    if (stat.cnt_one) begin
                        case (kind_reg)
                            FK_STARTER: state_next = ST_EMIT;
                            FK_OVF:     state_next = ST_INSERT;
                            default:    state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_item = 1'b1;
                    cmd.out_last  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_INSERT: begin
                cmd.ins_held = 1'b1;
                if (stat.held_eot) begin
                    kind_next  = FK_EOT;
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/canonical_mark_reorder.sv]
// Canonical ordering of combining marks. Each item is a code point with its combining
// class; marks (nonzero class) are held in a MAX_RUN-entry buffer kept stably sorted by
// class, and a starter or an item with tlast set flushes the run in order, m_tlast marking
// the final result of each item and m_tuser flagging marks flushed early on a full buffer.
// A mark that is only stored is inserted into the buffer as it is accepted. An item that
// produces results is accepted first, then the buffer head moves into the output register
// once per cycle while the output register is free; a mark arriving on a full buffer is
// inserted after the early flush. Intake is closed while results are being produced.
module canonical_mark_reorder #(
    parameter int MAX_RUN = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cmr_pkg::TDATA_W-1:0] s_tdata,   // code_point, combining_class, zero pad
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cmr_pkg::TDATA_W-1:0] m_tdata,   // out_code_point, out_class, zero pad
    output logic                        m_tlast,
    output logic [0:0]                  m_tuser    // overflowed
);
    import cmr_pkg::*;

    cmr_cmd_t  cmd;
    cmr_stat_t stat;

    cmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cmr_datapath #(
        .MAX_RUN (MAX_RUN)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/cmr_checker.sv]
module cmr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [cmr_pkg::TDATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cmr_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic [0:0]                  m_tuser
);
    import cmr_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // a starter always produces output, so intake must close after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[CP_W +: CLS_W] == '0) |=> !s_tready)
        else $error("intake stayed open after a starter");

    // a starter is always the final result of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[CP_W +: CLS_W] == '0) |-> m_tlast && !m_tuser[0])
        else $error("starter result not marked last");

    // early flushed results are always marks
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[CP_W +: CLS_W] != '0))
        else $error("overflow flag on a starter");

endmodule

bind canonical_mark_reorder cmr_checker u_cmr_checker (.*);
